/* rtl/path_latency_profiler_assert.svh */
// Assertion macros for the profiler RTL; plp_seq is the file that includes them.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PATH_LATENCY_PROFILER_ASSERT_SVH
`define PATH_LATENCY_PROFILER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/plp_pkg.sv */
// Shared types and constants of the path latency profiler.
// No dependencies; imported by the interfaces, plp_seq and path_latency_profiler.
package plp_pkg;

    localparam int OP_W     = 2;
    localparam int PATH_W   = 4;
    localparam int LOC_W    = 5;
    localparam int TIME_W   = 63;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = 64;
    localparam int CNT_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_MARK  = 2'd1,
        OP_END   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_SEQ_ERR   = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // One statistics memory word. The per-path counter slot keeps
    // {runs, unfinished} in the sum field and leaves cnt at zero.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } stat_word_t;

endpackage

/* rtl/plp_cmd_if.sv */
// Command channel of the profiler: valid/ready plus one operation word.
// Depends on plp_pkg for the field widths.
interface plp_cmd_if import plp_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [PATH_W-1:0]   path_id;
    logic [LOC_W-1:0]    location;
    logic [TIME_W-1:0]   now_time;

    modport source (output valid, operation, path_id, location, now_time, input ready);
    modport sink   (input valid, operation, path_id, location, now_time, output ready);

endinterface

/* rtl/plp_rsp_if.sv */
// Result channel of the profiler: valid/ready plus one result word.
// Depends on plp_pkg for the field widths.
interface plp_rsp_if import plp_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    path_runs;
    logic [CNT_W-1:0]    path_unfinished;
    logic [SUM_W-1:0]    point_sum;
    logic [CNT_W-1:0]    point_count;

    modport source (output valid, status, path_runs, path_unfinished, point_sum,
                    point_count, input ready);
    modport sink   (input valid, status, path_runs, path_unfinished, point_sum,
                    point_count, output ready);

endinterface

/* rtl/plp_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependency; used for the stamp and statistics stores.
module plp_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/plp_seq.sv */
// Operation sequencer: clearing sweep, per-operation memory walks, result register.
// Depends on plp_pkg, plp_cmd_if, plp_rsp_if and the assertion macro header.
`include "path_latency_profiler_assert.svh"

module plp_seq import plp_pkg::*; #(
    parameter int NUM_PATHS  = 16,
    parameter int NUM_POINTS = 16
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    plp_cmd_if.sink                                         cmd,
    plp_rsp_if.source                                       rsp,
    output logic                                            stamp_we,
    output logic [((NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1)
                  + $clog2(NUM_POINTS)-1:0]                 stamp_waddr,
    output logic [TIME_W-1:0]                               stamp_wdata,
    output logic                                            stamp_re,
    output logic [((NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1)
                  + $clog2(NUM_POINTS)-1:0]                 stamp_raddr,
    input  logic [TIME_W-1:0]                               stamp_rdata,
    output logic                                            stat_we,
    output logic [((NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1)
                  + $clog2(NUM_POINTS + 1)-1:0]             stat_waddr,
    output stat_word_t                                      stat_wdata,
    output logic                                            stat_re,
    output logic [((NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1)
                  + $clog2(NUM_POINTS + 1)-1:0]             stat_raddr,
    input  stat_word_t                                      stat_rdata
);

    localparam int PAW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int PW  = $clog2(NUM_POINTS);
    localparam int LW  = $clog2(NUM_POINTS + 1);
    localparam int SAW = PAW + LW;

    localparam logic [LW-1:0] CNT_SLOT  = LW'(NUM_POINTS);
    localparam logic [PW-1:0] PT_FIRST  = PW'(1);
    localparam logic [PW-1:0] PT_ZERO   = PW'(0);
    localparam logic [PW-1:0] PT_LAST   = PW'(NUM_POINTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_START_CLR,
        S_RD_PT,
        S_END_SCAN,
        S_ACC_SUB,
        S_ACC_WR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [SAW-1:0]     clr_reg, clr_next;
    logic [PW-1:0]      pt_reg, pt_next;
    op_t                op_reg, op_next;
    logic [PAW-1:0]     path_reg, path_next;
    logic [LW-1:0]      loc_reg, loc_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  begin_reg, begin_next;
    logic [SUM_W-1:0]   diff_reg, diff_next;
    logic               miss_reg, miss_next;
    logic               extra_reg, extra_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   runs_reg, runs_next;
    logic [CNT_W-1:0]   unf_reg, unf_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               rsp_valid_reg, rsp_valid_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [CNT_W-1:0]   rsp_runs_reg, rsp_runs_next;
    logic [CNT_W-1:0]   rsp_unf_reg, rsp_unf_next;
    logic [SUM_W-1:0]   rsp_sum_reg, rsp_sum_next;
    logic [CNT_W-1:0]   rsp_cnt_reg, rsp_cnt_next;

    logic               in_bad;
    logic [PAW-1:0]     in_path;
    logic [LW-1:0]      in_loc;
    logic [LW-1:0]      pt_lw;
    logic               miss_w;
    logic               extra_w;
    logic [CNT_W-1:0]   fetch_runs;
    logic [CNT_W-1:0]   fetch_unf;

    // Decode the incoming word and range-check its indexes
    always_comb
    begin
        in_path = PAW'(cmd.path_id);
        in_loc  = LW'(cmd.location);
        in_bad  = int'(cmd.path_id) >= NUM_PATHS;
        unique case (op_t'(cmd.operation))
            OP_START: in_bad = in_bad;
            OP_MARK:  in_bad = in_bad || (cmd.location == '0)
                               || (int'(cmd.location) >= NUM_POINTS);
            OP_END:   in_bad = in_bad || (int'(cmd.location) > NUM_POINTS);
            OP_READ:  in_bad = in_bad || (int'(cmd.location) >= NUM_POINTS);
        endcase
    end

    // Scan flags, including the point whose stamp arrives this cycle
    assign pt_lw      = LW'(pt_reg);
    assign miss_w     = miss_reg  || ((pt_lw < loc_reg)  && (stamp_rdata == '0));
    assign extra_w    = extra_reg || ((pt_lw >= loc_reg) && (stamp_rdata != '0));
    assign fetch_runs = stat_rdata.sum[SUM_W-1:CNT_W];
    assign fetch_unf  = stat_rdata.sum[CNT_W-1:0];

    assign cmd.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.path_runs       = rsp_runs_reg;
    assign rsp.path_unfinished = rsp_unf_reg;
    assign rsp.point_sum       = rsp_sum_reg;
    assign rsp.point_count     = rsp_cnt_reg;

    // Next-state and memory port control
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pt_next         = pt_reg;
        op_next         = op_reg;
        path_next       = path_reg;
        loc_next        = loc_reg;
        now_next        = now_reg;
        begin_next      = begin_reg;
        diff_next       = diff_reg;
        miss_next       = miss_reg;
        extra_next      = extra_reg;
        status_next     = status_reg;
        runs_next       = runs_reg;
        unf_next        = unf_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_runs_next   = rsp_runs_reg;
        rsp_unf_next    = rsp_unf_reg;
        rsp_sum_next    = rsp_sum_reg;
        rsp_cnt_next    = rsp_cnt_reg;

        stamp_we    = 1'b0;
        stamp_waddr = {path_reg, PT_ZERO};
        stamp_wdata = '0;
        stamp_re    = 1'b0;
        stamp_raddr = {path_reg, PT_ZERO};
        stat_we     = 1'b0;
        stat_waddr  = {path_reg, CNT_SLOT};
        stat_wdata  = '0;
        stat_re     = 1'b0;
        stat_raddr  = {path_reg, CNT_SLOT};

        unique case (state_reg)
            // Zero both stores one row per cycle after reset
            S_CLEAR:
            begin
                stamp_we    = 1'b1;
                stamp_waddr = clr_reg[PAW+PW-1:0];
                stat_we     = 1'b1;
                stat_waddr  = clr_reg;
                clr_next    = clr_reg + SAW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a word, fetch the path counters and the start stamp
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = op_t'(cmd.operation);
                    path_next   = in_path;
                    loc_next    = in_loc;
                    now_next    = cmd.now_time;
                    status_next = ST_OK;
                    sum_next    = '0;
                    cnt_next    = '0;
                    miss_next   = 1'b0;
                    extra_next  = 1'b0;
                    stat_re     = 1'b1;
                    stat_raddr  = {in_path, CNT_SLOT};
                    stamp_re    = 1'b1;
                    stamp_raddr = {in_path, PT_ZERO};
                    if (in_bad)
                    begin
                        status_next = ST_BAD_INDEX;
                        runs_next   = '0;
                        unf_next    = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            // Counters and start stamp are here: branch on the operation
            S_FETCH:
            begin
                runs_next = fetch_runs;
                unf_next  = fetch_unf;
                unique case (op_reg)
                    OP_START:
                    begin
                        runs_next        = fetch_runs + CNT_W'(1);
                        unf_next         = fetch_unf + CNT_W'(stamp_rdata != '0);
                        stat_we          = 1'b1;
                        stat_wdata.sum   = {fetch_runs + CNT_W'(1),
                                            fetch_unf + CNT_W'(stamp_rdata != '0)};
                        stamp_we         = 1'b1;
                        stamp_wdata      = now_reg;
                        pt_next          = PT_FIRST;
                        state_next       = S_START_CLR;
                    end
                    OP_MARK:
                    begin
                        stamp_we    = 1'b1;
                        stamp_waddr = {path_reg, PW'(loc_reg)};
                        stamp_wdata = now_reg;
                        state_next  = S_DONE;
                    end
                    OP_END:
                    begin
                        begin_next  = stamp_rdata;
                        miss_next   = (loc_reg != '0) && (stamp_rdata == '0);
                        extra_next  = (loc_reg == '0) && (stamp_rdata != '0);
                        stamp_re    = 1'b1;
                        stamp_raddr = {path_reg, PT_FIRST};
                        pt_next     = PT_FIRST;
                        state_next  = S_END_SCAN;
                    end
                    OP_READ:
                    begin
                        stat_re    = 1'b1;
                        stat_raddr = {path_reg, loc_reg};
                        state_next = S_RD_PT;
                    end
                endcase
            end

            // Drop the stamps of points one and up
            S_START_CLR:
            begin
                stamp_we    = 1'b1;
                stamp_waddr = {path_reg, pt_reg};
                pt_next     = pt_reg + PW'(1);
                if (pt_reg == PT_LAST)
                begin
                    state_next = S_DONE;
                end
            end

            // Hold the point statistics for the result
            S_RD_PT:
            begin
                sum_next   = stat_rdata.sum;
                cnt_next   = stat_rdata.cnt;
                state_next = S_DONE;
            end

            // Walk all stamps of the path, one per cycle
            S_END_SCAN:
            begin
                miss_next  = miss_w;
                extra_next = extra_w;
                if (pt_reg == PT_LAST)
                begin
                    if (miss_w)
                    begin
                        stamp_we    = 1'b1;
                        status_next = ST_DROPPED;
                        state_next  = S_DONE;
                    end
                    else if (extra_w)
                    begin
                        status_next = ST_SEQ_ERR;
                        state_next  = S_DONE;
                    end
                    else if (loc_reg > LW'(1))
                    begin
                        stamp_re    = 1'b1;
                        stamp_raddr = {path_reg, PT_FIRST};
                        stat_re     = 1'b1;
                        stat_raddr  = {path_reg, LW'(PT_FIRST)};
                        pt_next     = PT_FIRST;
                        state_next  = S_ACC_SUB;
                    end
                    else
                    begin
                        stamp_we   = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    stamp_re    = 1'b1;
                    stamp_raddr = {path_reg, pt_reg + PW'(1)};
                    pt_next     = pt_reg + PW'(1);
                end
            end

            // Form the offset from the start and unstamp the point
            S_ACC_SUB:
            begin
                diff_next   = {1'b0, stamp_rdata} - {1'b0, begin_reg};
                stamp_we    = 1'b1;
                stamp_waddr = {path_reg, pt_reg};
                state_next  = S_ACC_WR;
            end

            // Accumulate the sample, then advance or finish
            S_ACC_WR:
            begin
                stat_we        = 1'b1;
                stat_waddr     = {path_reg, pt_lw};
                stat_wdata.sum = stat_rdata.sum + diff_reg;
                stat_wdata.cnt = stat_rdata.cnt + CNT_W'(1);
                if (pt_lw == loc_reg - LW'(1))
                begin
                    stamp_we   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    stamp_re    = 1'b1;
                    stamp_raddr = {path_reg, pt_reg + PW'(1)};
                    stat_re     = 1'b1;
                    stat_raddr  = {path_reg, LW'(pt_reg + PW'(1))};
                    pt_next     = pt_reg + PW'(1);
                    state_next  = S_ACC_SUB;
                end
            end

            // Move the result into the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_runs_next   = runs_reg;
                    rsp_unf_next    = unf_reg;
                    rsp_sum_next    = sum_reg;
                    rsp_cnt_next    = cnt_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            pt_reg         <= '0;
            op_reg         <= OP_START;
            path_reg       <= '0;
            loc_reg        <= '0;
            now_reg        <= '0;
            begin_reg      <= '0;
            diff_reg       <= '0;
            miss_reg       <= 1'b0;
            extra_reg      <= 1'b0;
            status_reg     <= ST_OK;
            runs_reg       <= '0;
            unf_reg        <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_runs_reg   <= '0;
            rsp_unf_reg    <= '0;
            rsp_sum_reg    <= '0;
            rsp_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pt_reg         <= pt_next;
            op_reg         <= op_next;
            path_reg       <= path_next;
            loc_reg        <= loc_next;
            now_reg        <= now_next;
            begin_reg      <= begin_next;
            diff_reg       <= diff_next;
            miss_reg       <= miss_next;
            extra_reg      <= extra_next;
            status_reg     <= status_next;
            runs_reg       <= runs_next;
            unf_reg        <= unf_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_runs_reg   <= rsp_runs_next;
            rsp_unf_reg    <= rsp_unf_next;
            rsp_sum_reg    <= rsp_sum_next;
            rsp_cnt_reg    <= rsp_cnt_next;
        end
    end

    // Checks
    `PLP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, cmd.valid && cmd.ready,
        state_reg != S_IDLE && state_reg != S_CLEAR, "accepted word did not start work")
    `PLP_ASSERT_NOW(a_stat_no_collide, clk, rst_n, stat_we && stat_re,
        stat_waddr != stat_raddr, "statistics read and write hit the same entry")
    `PLP_ASSERT_NOW(a_stamp_no_collide, clk, rst_n, stamp_we && stamp_re,
        stamp_waddr != stamp_raddr, "stamp read and write hit the same entry")
    `PLP_ASSERT_NOW(a_bad_index_zero, clk, rst_n,
        rsp_valid_reg && rsp_status_reg == ST_BAD_INDEX,
        rsp_runs_reg == '0 && rsp_unf_reg == '0 && rsp_sum_reg == '0 && rsp_cnt_reg == '0,
        "bad index result carries nonzero fields")

endmodule

/* rtl/path_latency_profiler.sv */
// Per-path latency profiler. Channels: cmd (sink) takes one operation word,
// start / mark / end / read, with path_id, location and now_time; rsp (source)
// returns one result word per command: status, path_runs, path_unfinished and,
// on read, point_sum and point_count. Both are valid/ready channels.
// Commands are handled one at a time. A bad index goes straight to the result;
// a mark writes one stamp; a read fetches the point statistics; a start updates
// the path counters and start stamp, then clears the stamps of points one and up.
// An end walks the stamp memory (one point per cycle) and finishes there on drop,
// sequence error or a count of one or less; otherwise it accumulates each point
// from one up to count - 1 by a read-modify-write of the stats memory.
// A finished result sits in an output register; the next command is taken
// while it waits, and a stalled receiver only holds the sequencer once the
// following result is ready. After reset the block zeroes both memories,
// one entry per cycle, with cmd.ready low.
// Depends on plp_pkg, plp_cmd_if, plp_rsp_if, plp_ram and plp_seq.
module path_latency_profiler import plp_pkg::*; #(
    parameter int NUM_PATHS  = 16,
    parameter int NUM_POINTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    plp_cmd_if.sink   cmd,
    plp_rsp_if.source rsp
);

    localparam int PAW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int PW  = $clog2(NUM_POINTS);
    localparam int LW  = $clog2(NUM_POINTS + 1);

    logic                stamp_we;
    logic [PAW+PW-1:0]   stamp_waddr;
    logic [TIME_W-1:0]   stamp_wdata;
    logic                stamp_re;
    logic [PAW+PW-1:0]   stamp_raddr;
    logic [TIME_W-1:0]   stamp_rdata;
    logic                stat_we;
    logic [PAW+LW-1:0]   stat_waddr;
    stat_word_t          stat_wdata;
    logic                stat_re;
    logic [PAW+LW-1:0]   stat_raddr;
    stat_word_t          stat_rdata;

    // Sequencer and result register
    plp_seq #(
        .NUM_PATHS  (NUM_PATHS),
        .NUM_POINTS (NUM_POINTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .stamp_we    (stamp_we),
        .stamp_waddr (stamp_waddr),
        .stamp_wdata (stamp_wdata),
        .stamp_re    (stamp_re),
        .stamp_raddr (stamp_raddr),
        .stamp_rdata (stamp_rdata),
        .stat_we     (stat_we),
        .stat_waddr  (stat_waddr),
        .stat_wdata  (stat_wdata),
        .stat_re     (stat_re),
        .stat_raddr  (stat_raddr),
        .stat_rdata  (stat_rdata)
    );

    // Stamp store: one time stamp per path and point
    plp_ram #(
        .WIDTH (TIME_W),
        .AW    (PAW + PW)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_wdata),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    // Statistics store: sum and count per point, plus a per-path counter slot
    plp_ram #(
        .WIDTH ($bits(stat_word_t)),
        .AW    (PAW + LW)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .re    (stat_re),
        .raddr (stat_raddr),
        .rdata (stat_rdata)
    );

endmodule

/* dv/path_latency_profiler_tb.sv */
// Testbench for path_latency_profiler: directed and random start/mark/end/read words,
// checked against an in-bench model of the stamp, sum and counter stores.
// Depends on plp_pkg, plp_cmd_if, plp_rsp_if and the profiler RTL.
module path_latency_profiler_tb;
    import plp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PATHS    = 16;
    localparam int NUM_POINTS   = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_WORDS = 880;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct {
        status_t          status;
        logic [CNT_W-1:0] runs;
        logic [CNT_W-1:0] unfinished;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } profile_result_t;

    logic clk;
    logic rst_n;

    plp_cmd_if cmd_ch ();
    plp_rsp_if rsp_ch ();

    path_latency_profiler #(
        .NUM_PATHS  (NUM_PATHS),
        .NUM_POINTS (NUM_POINTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Model of the profiler stores
    logic [SUM_W-1:0] stamp_mem   [NUM_PATHS][NUM_POINTS];
    logic [SUM_W-1:0] latency_acc [NUM_PATHS][NUM_POINTS];
    logic [CNT_W-1:0] sample_acc  [NUM_PATHS][NUM_POINTS];
    logic [CNT_W-1:0] run_ctr     [NUM_PATHS];
    logic [CNT_W-1:0] unfin_ctr   [NUM_PATHS];

    profile_result_t pending_results[$];

    int  fail_count;
    int  sent_words;
    bit  gaps_on;
    bit  stalls_on;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Apply one command word to the model and return the result word it yields
    function automatic profile_result_t apply_profile_op(op_t op, logic [PATH_W-1:0] path,
                                                          logic [LOC_W-1:0] loc,
                                                          logic [TIME_W-1:0] now);
        profile_result_t  res;
        bit               bad;
        bit               missing;
        bit               extra;
        bit               stamped;
        logic [SUM_W-1:0] begin_stamp;
        int               p;
        int               n;

        res = '{ST_OK, '0, '0, '0, '0};
        p   = int'(path);
        n   = int'(loc);
        bad = (p >= NUM_PATHS);
        if (!bad)
        begin
            case (op)
                OP_MARK: bad = (n == 0) || (n >= NUM_POINTS);
                OP_END:  bad = (n > NUM_POINTS);
                OP_READ: bad = (n >= NUM_POINTS);
                default: bad = 1'b0;
            endcase
        end
        if (bad)
        begin
            res.status = ST_BAD_INDEX;
            return res;
        end

        case (op)
            OP_START:
            begin
                if (stamp_mem[p][0] != '0)
                    unfin_ctr[p] = unfin_ctr[p] + CNT_W'(1);
                run_ctr[p] = run_ctr[p] + CNT_W'(1);
                for (int i = 1; i < NUM_POINTS; i++)
                    stamp_mem[p][i] = '0;
                stamp_mem[p][0] = {1'b0, now};
            end
            OP_MARK:
                stamp_mem[p][n] = {1'b0, now};
            OP_END:
            begin
                missing     = 1'b0;
                extra       = 1'b0;
                begin_stamp = stamp_mem[p][0];
                for (int i = 0; i < NUM_POINTS; i++)
                begin
                    stamped = (stamp_mem[p][i] != '0);
                    if (i < n && !stamped)
                        missing = 1'b1;
                    if (i >= n && stamped)
                        extra = 1'b1;
                end
                if (missing)
                begin
                    // drop the run: only the start stamp goes
                    stamp_mem[p][0] = '0;
                    res.status      = ST_DROPPED;
                end
                else if (extra)
                    res.status = ST_SEQ_ERR;
                else
                begin
                    for (int i = 1; i < n; i++)
                    begin
                        latency_acc[p][i] = latency_acc[p][i] + (stamp_mem[p][i] - begin_stamp);
                        sample_acc[p][i]  = sample_acc[p][i] + CNT_W'(1);
                        stamp_mem[p][i]   = '0;
                    end
                    stamp_mem[p][0] = '0;
                end
            end
            default:
            begin
                res.sum   = latency_acc[p][n];
                res.count = sample_acc[p][n];
            end
        endcase
        res.runs       = run_ctr[p];
        res.unfinished = unfin_ctr[p];
        return res;
    endfunction

    // Mostly short waits, now and then a long one
    function automatic int gap_len();
        int r;

        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] w;

        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Send one command word and record its expected result once accepted
    task automatic send_word(op_t op, logic [PATH_W-1:0] path, logic [LOC_W-1:0] loc,
                             logic [TIME_W-1:0] now);
        int gap;

        gap = 0;
        if (gaps_on && $urandom_range(0, 1) == 0)
            gap = gap_len() + 1;
        repeat (gap)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.path_id   <= path;
        cmd_ch.location  <= loc;
        cmd_ch.now_time  <= now;
        forever
        begin
            @(posedge clk);
            if (cmd_ch.ready)
                break;
        end
        pending_results.push_back(apply_profile_op(op, path, loc, now));
        sent_words++;
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        profile_result_t exp;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                fail_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (rsp_ch.status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.path_runs !== exp.runs)
                begin
                    $error("path_runs: expected %0d, got %0d", exp.runs, rsp_ch.path_runs);
                    fail_count++;
                end
                if (rsp_ch.path_unfinished !== exp.unfinished)
                begin
                    $error("path_unfinished: expected %0d, got %0d", exp.unfinished,
                           rsp_ch.path_unfinished);
                    fail_count++;
                end
                if (rsp_ch.point_sum !== exp.sum)
                begin
                    $error("point_sum: expected %0h, got %0h", exp.sum, rsp_ch.point_sum);
                    fail_count++;
                end
                if (rsp_ch.point_count !== exp.count)
                begin
                    $error("point_count: expected %0d, got %0d", exp.count,
                           rsp_ch.point_count);
                    fail_count++;
                end
            end
        end
    end

    // Stall the result channel at random
    initial
    begin : drive_rsp_ready
        int hold;

        hold         = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold = gap_len();
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // End the run when neither channel moves a word for too long
    initial
    begin : watchdog
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Index checks: marks at point 0 or past the last point, end count too big,
    // read past the last point
    task automatic test_bad_index();
        send_word(OP_MARK, 4'd0, 5'd0, 63'd77);
        send_word(OP_MARK, 4'd9, 5'd16, 63'd77);
        send_word(OP_END, 4'd2, 5'd17, 63'd0);
        send_word(OP_READ, 4'd1, 5'd16, 63'd0);
        send_word(OP_READ, 4'd0, 5'd31, TIME_MAX);
    endtask

    // Full run with the largest stamp, then read back the points
    task automatic test_basic_run();
        send_word(OP_START, 4'd15, 5'd31, 63'd100);
        send_word(OP_MARK, 4'd15, 5'd1, 63'd150);
        send_word(OP_MARK, 4'd15, 5'd2, TIME_MAX);
        send_word(OP_END, 4'd15, 5'd3, 63'd0);
        send_word(OP_READ, 4'd15, 5'd2, 63'd0);
        send_word(OP_READ, 4'd15, 5'd1, 63'd0);
    endtask

    // Incomplete path: a missing point drops the run, so a new start is clean
    task automatic test_dropped_path();
        send_word(OP_START, 4'd1, 5'd0, 63'd500);
        send_word(OP_END, 4'd1, 5'd2, 63'd0);
        send_word(OP_START, 4'd1, 5'd0, 63'd600);
    endtask

    // Sequence error: a point past the end count is stamped; restart counts unfinished
    task automatic test_sequence_error();
        send_word(OP_START, 4'd2, 5'd0, 63'd10);
        send_word(OP_MARK, 4'd2, 5'd1, 63'd20);
        send_word(OP_MARK, 4'd2, 5'd3, 63'd30);
        send_word(OP_END, 4'd2, 5'd2, 63'd0);
        send_word(OP_START, 4'd2, 5'd0, 63'd40);
    endtask

    // End count of zero on an idle path, and full count on an empty path
    task automatic test_end_count_zero();
        send_word(OP_END, 4'd3, 5'd0, 63'd0);
        send_word(OP_END, 4'd3, 5'd16, 63'd0);
    endtask

    // A start at time zero leaves the path unstamped
    task automatic test_zero_stamp();
        send_word(OP_START, 4'd4, 5'd0, 63'd0);
        send_word(OP_END, 4'd4, 5'd1, 63'd0);
    endtask

    // A point stamped before its start wraps the offset
    task automatic test_offset_wrap();
        send_word(OP_START, 4'd5, 5'd0, 63'd1000);
        send_word(OP_MARK, 4'd5, 5'd1, 63'd5);
        send_word(OP_END, 4'd5, 5'd2, 63'd0);
        send_word(OP_READ, 4'd5, 5'd1, 63'd0);
    endtask

    // One run on a random path; flaw 0 none, 1 skip a mark, 2 extra mark,
    // 3 zero-time mark, 4 restart before the end
    task automatic run_path_sequence(int flaw);
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t;
        int                cnt;
        int                nmarks;
        int                skip;
        int                j;
        int                tmp;
        int                order[NUM_POINTS];

        path = PATH_W'($urandom_range(0, NUM_PATHS - 1));
        tmp  = $urandom_range(0, 99);
        if (tmp < 8)
            cnt = NUM_POINTS;
        else if (tmp < 14)
            cnt = 0;
        else
            cnt = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
            t0 = TIME_W'($urandom_range(1, 2000));
        else
            t0 = rand_time();
        if (t0 == '0)
            t0 = TIME_W'(1);

        send_word(OP_START, path, LOC_W'($urandom_range(0, 31)), t0);
        if (flaw == 4)
            send_word(OP_START, path, 5'd0, t0 + TIME_W'($urandom_range(1, 100)));

        // mark the points in shuffled order
        nmarks = (cnt > 1) ? cnt - 1 : 0;
        for (int i = 0; i < NUM_POINTS; i++)
            order[i] = i + 1;
        for (int i = nmarks - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skip = (flaw == 1 && nmarks > 0) ? $urandom_range(0, nmarks - 1) : -1;
        for (int i = 0; i < nmarks; i++)
        begin
            if (i == skip)
                continue;
            t = t0 + TIME_W'($urandom_range(1, 5000));
            if ($urandom_range(0, 19) == 0)
                t = rand_time();
            if (flaw == 3 && i == 0)
                t = '0;
            send_word(OP_MARK, path, LOC_W'(order[i]), t);
            if ($urandom_range(0, 9) == 0)
                send_word(OP_READ, PATH_W'($urandom_range(0, NUM_PATHS - 1)),
                          LOC_W'($urandom_range(0, NUM_POINTS - 1)), rand_time());
        end
        if (flaw == 2 && cnt < NUM_POINTS)
            send_word(OP_MARK, path,
                      LOC_W'($urandom_range((cnt > 1) ? cnt : 1, NUM_POINTS - 1)),
                      t0 + TIME_W'($urandom_range(1, 5000)));

        send_word(OP_END, path, LOC_W'(cnt), rand_time());
        repeat ($urandom_range(0, 2))
            send_word(OP_READ, path, LOC_W'($urandom_range(0, NUM_POINTS - 1)),
                      rand_time());
    endtask

    // Mostly well-formed runs, some flawed runs, some random words
    task automatic test_random_traffic();
        int target;
        int next_mode;
        int r;

        target    = sent_words + RANDOM_WORDS;
        next_mode = sent_words;
        while (sent_words < target)
        begin
            // switch idling on and off in stretches
            if (sent_words >= next_mode)
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
                next_mode = sent_words + $urandom_range(50, 150);
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                run_path_sequence(0);
            else if (r < 85)
                run_path_sequence($urandom_range(1, 4));
            else
                repeat ($urandom_range(1, 4))
                    send_word(op_t'($urandom_range(0, 3)),
                              PATH_W'($urandom_range(0, NUM_PATHS - 1)),
                              LOC_W'($urandom_range(0, 31)),
                              ($urandom_range(0, 9) == 0) ? '0 : rand_time());
        end
    endtask

    initial
    begin
        fail_count       = 0;
        sent_words       = 0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = '0;
        cmd_ch.path_id   = '0;
        cmd_ch.location  = '0;
        cmd_ch.now_time  = '0;
        for (int p = 0; p < NUM_PATHS; p++)
        begin
            run_ctr[p]   = '0;
            unfin_ctr[p] = '0;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                stamp_mem[p][i]   = '0;
                latency_acc[p][i] = '0;
                sample_acc[p][i]  = '0;
            end
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_index();
        test_basic_run();
        test_dropped_path();
        test_sequence_error();
        test_end_count_zero();
        test_zero_stamp();
        test_offset_wrap();
        test_random_traffic();

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        stalls_on = 1'b0;

        // drain, then hold for any stray word
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
